FILE: rtl/complex_basis_projection_assert.svh
// assertion macros for the projection block rtl
// used by files that include this header; needs aclk and aresetn in scope
`ifndef COMPLEX_BASIS_PROJECTION_ASSERT_SVH
`define COMPLEX_BASIS_PROJECTION_ASSERT_SVH

// property holds at every edge out of reset
`define CBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cbp_pkg.sv
// shared types, codes and fixed-point helpers for the projection block
// no dependencies
package cbp_pkg;

    // default sizes of the stores
    localparam int DEF_MAX_ORBITALS = 64;
    localparam int DEF_MAX_BANDS    = 64;
    localparam int DEF_MAX_SPINORS  = 2;

    // request codes carried in tuser
    localparam logic [1:0] REQ_LOAD_POT = 2'd0;
    localparam logic [1:0] REQ_LOAD_WFC = 2'd1;
    localparam logic [1:0] REQ_COMPUTE  = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_ORBITALS = 2'd0;
    localparam logic [1:0] CFG_BANDS    = 2'd1;
    localparam logic [1:0] CFG_SPINORS  = 2'd2;

    localparam logic [6:0] ORBITALS_RESET = 7'd64;
    localparam logic [6:0] BANDS_RESET    = 7'd64;
    localparam logic [1:0] SPINORS_RESET  = 2'd1;

    // controller to datapath commands
    typedef struct packed {
        logic load_pot;
        logic load_wfc;
        logic start;
        logic issue;
        logic finish;
    } cbp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } cbp_sts_t;

    // Q8.24 product rounded half up, floor of (p + 2^23) / 2^24
    function automatic logic signed [39:0] rmul(input logic signed [63:0] p);
        logic signed [63:0] y;
        y = p + 64'sd8388608;
        return y[63:24];
    endfunction

    function automatic logic signed [31:0] sat32_41(input logic signed [40:0] v);
        if (v > 41'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -41'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat32_64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage

FILE: rtl/complex_basis_projection.sv
// Complex basis projection. A load item (tuser 0 potential, 1 wavefunction)
// writes one element into on-chip memory; there is no clearing pass, so
// every element must be written before a compute reads it. A compute item
// (tuser 2) sums conj(W[bra,r]) V[r,c] W[ket,c] over spinors, rows and
// columns and yields one result item. One product term leaves the memory
// read ports each cycle into the multiply pipeline. A compute naming a band
// at or beyond band_count yields zero. A result waiting in the output
// register does not block further loads. Config writes are taken at any
// cycle.
// depends on cbp_pkg, cbp_controller, cbp_datapath, cbp_ram
module complex_basis_projection import cbp_pkg::*; #(
    parameter int MAX_ORBITALS = DEF_MAX_ORBITALS,
    parameter int MAX_BANDS    = DEF_MAX_BANDS,
    parameter int MAX_SPINORS  = DEF_MAX_SPINORS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_index, second_index, spinor_index, real_part, imag_part, zero fill
    input  logic [79:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bra_band, ket_band, result_real, result_imag, zero fill
    output logic [79:0] m_tdata
);
    localparam int ORB_W = MAX_ORBITALS > 1 ? $clog2(MAX_ORBITALS) : 1;
    localparam int SP_W  = MAX_SPINORS > 1 ? $clog2(MAX_SPINORS) : 1;

    cbp_cmd_t cmd;
    cbp_sts_t sts;
    logic [SP_W-1:0]  spin;
    logic [ORB_W-1:0] row, col;
    logic [5:0]  bra_band, ket_band;
    logic [31:0] result_real, result_imag;

    cbp_controller #(
        .MAX_ORBITALS(MAX_ORBITALS), .MAX_BANDS(MAX_BANDS), .MAX_SPINORS(MAX_SPINORS)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .req_type(s_tuser),
        .first_index(s_tdata[5:0]), .second_index(s_tdata[11:6]),
        .cmd(cmd), .sts(sts), .spin(spin), .row(row), .col(col)
    );

    cbp_datapath #(
        .MAX_ORBITALS(MAX_ORBITALS), .MAX_BANDS(MAX_BANDS), .MAX_SPINORS(MAX_SPINORS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .spin(spin), .row(row), .col(col),
        .first_index(s_tdata[5:0]), .second_index(s_tdata[11:6]),
        .spinor_index(s_tdata[12]), .real_part(s_tdata[44:13]),
        .imag_part(s_tdata[76:45]),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .bra_band(bra_band), .ket_band(ket_band),
        .result_real(result_real), .result_imag(result_imag)
    );

    // pack result item
    assign m_tdata = {4'd0, result_imag, result_real, ket_band, bra_band};
endmodule

FILE: rtl/cbp_ram.sv
// generic single write port, single registered read port memory
// no dependencies
module cbp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/cbp_datapath.sv
// stores, product pipeline, accumulators and result register
// depends on cbp_pkg and cbp_ram
module cbp_datapath import cbp_pkg::*; #(
    parameter int MAX_ORBITALS = DEF_MAX_ORBITALS,
    parameter int MAX_BANDS    = DEF_MAX_BANDS,
    parameter int MAX_SPINORS  = DEF_MAX_SPINORS,
    localparam int ORB_W  = MAX_ORBITALS > 1 ? $clog2(MAX_ORBITALS) : 1,
    localparam int SP_W   = MAX_SPINORS > 1 ? $clog2(MAX_SPINORS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cbp_cmd_t           cmd,
    output cbp_sts_t           sts,
    input  logic [SP_W-1:0]    spin,
    input  logic [ORB_W-1:0]   row,
    input  logic [ORB_W-1:0]   col,
    input  logic [5:0]         first_index,
    input  logic [5:0]         second_index,
    input  logic               spinor_index,
    input  logic [31:0]        real_part,
    input  logic [31:0]        imag_part,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [5:0]         bra_band,
    output logic [5:0]         ket_band,
    output logic [31:0]        result_real,
    output logic [31:0]        result_imag
);
    localparam int POT_DEPTH = MAX_ORBITALS * MAX_ORBITALS;
    localparam int WFC_DEPTH = MAX_SPINORS * MAX_BANDS * MAX_ORBITALS;
    localparam int POT_AW = POT_DEPTH > 1 ? $clog2(POT_DEPTH) : 1;
    localparam int WFC_AW = WFC_DEPTH > 1 ? $clog2(WFC_DEPTH) : 1;

    logic [5:0]  bra_reg, ket_reg;
    logic [63:0] wdata;
    logic        pot_we, wfc_we;
    logic [POT_AW-1:0] pot_waddr, pot_raddr;
    logic [WFC_AW-1:0] wfc_waddr, bra_raddr, ket_raddr;
    logic [63:0] pot_rdata, bra_rdata, ket_rdata;

    // load addressing, out-of-range loads are dropped
    assign wdata  = {real_part, imag_part};
    assign pot_we = cmd.load_pot && (32'(first_index) < MAX_ORBITALS)
                    && (32'(second_index) < MAX_ORBITALS);
    assign wfc_we = cmd.load_wfc && (32'(first_index) < MAX_BANDS)
                    && (32'(second_index) < MAX_ORBITALS) && (32'(spinor_index) < MAX_SPINORS);
    assign pot_waddr = POT_AW'(32'(first_index) * MAX_ORBITALS + 32'(second_index));
    assign wfc_waddr = WFC_AW'((32'(spinor_index) * MAX_BANDS + 32'(first_index))
                               * MAX_ORBITALS + 32'(second_index));

    // read addressing for the current term
    assign pot_raddr = POT_AW'(32'(row) * MAX_ORBITALS + 32'(col));
    assign bra_raddr = WFC_AW'((32'(spin) * MAX_BANDS + 32'(bra_reg)) * MAX_ORBITALS
                               + 32'(row));
    assign ket_raddr = WFC_AW'((32'(spin) * MAX_BANDS + 32'(ket_reg)) * MAX_ORBITALS
                               + 32'(col));

    cbp_ram #(.WIDTH(64), .DEPTH(POT_DEPTH)) u_pot_ram (
        .aclk(aclk), .we(pot_we), .waddr(pot_waddr), .wdata(wdata),
        .raddr(pot_raddr), .rdata(pot_rdata)
    );
    // two copies of the wavefunctions give bra and ket reads in the same cycle
    cbp_ram #(.WIDTH(64), .DEPTH(WFC_DEPTH)) u_bra_ram (
        .aclk(aclk), .we(wfc_we), .waddr(wfc_waddr), .wdata(wdata),
        .raddr(bra_raddr), .rdata(bra_rdata)
    );
    cbp_ram #(.WIDTH(64), .DEPTH(WFC_DEPTH)) u_ket_ram (
        .aclk(aclk), .we(wfc_we), .waddr(wfc_waddr), .wdata(wdata),
        .raddr(ket_raddr), .rdata(ket_rdata)
    );

    logic rd_vld_reg, m1_vld_reg, t_vld_reg, m2_vld_reg, p_vld_reg;
    logic signed [63:0] vrkr_reg, viki_reg, vrki_reg, vikr_reg;
    logic [63:0] bra_m1_reg, bra_t_reg;
    logic signed [31:0] tr_reg, ti_reg;
    logic signed [63:0] brtr_reg, biti_reg, brti_reg, bitr_reg;
    logic signed [40:0] pr_reg, pi_reg;
    logic signed [63:0] acc_re_reg, acc_im_reg;
    logic out_vld_reg;
    logic [5:0] out_bra_reg, out_ket_reg;
    logic [31:0] out_re_reg, out_im_reg;

    // pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            m1_vld_reg <= 1'b0;
            t_vld_reg  <= 1'b0;
            m2_vld_reg <= 1'b0;
            p_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.issue;
            m1_vld_reg <= rd_vld_reg;
            t_vld_reg  <= m1_vld_reg;
            m2_vld_reg <= t_vld_reg;
            p_vld_reg  <= m2_vld_reg;
        end
    end

    // product pipeline: V times ket, round, then conj(bra) times that
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            bra_reg <= first_index;
            ket_reg <= second_index;
        end
        vrkr_reg   <= $signed(pot_rdata[63:32]) * $signed(ket_rdata[63:32]);
        viki_reg   <= $signed(pot_rdata[31:0])  * $signed(ket_rdata[31:0]);
        vrki_reg   <= $signed(pot_rdata[63:32]) * $signed(ket_rdata[31:0]);
        vikr_reg   <= $signed(pot_rdata[31:0])  * $signed(ket_rdata[63:32]);
        bra_m1_reg <= bra_rdata;
        tr_reg     <= sat32_41(41'(rmul(vrkr_reg)) - 41'(rmul(viki_reg)));
        ti_reg     <= sat32_41(41'(rmul(vrki_reg)) + 41'(rmul(vikr_reg)));
        bra_t_reg  <= bra_m1_reg;
        brtr_reg   <= $signed(bra_t_reg[63:32]) * tr_reg;
        biti_reg   <= $signed(bra_t_reg[31:0])  * ti_reg;
        brti_reg   <= $signed(bra_t_reg[63:32]) * ti_reg;
        bitr_reg   <= $signed(bra_t_reg[31:0])  * tr_reg;
        pr_reg     <= 41'(rmul(brtr_reg)) + 41'(rmul(biti_reg));
        pi_reg     <= 41'(rmul(brti_reg)) - 41'(rmul(bitr_reg));
    end

    // saturating accumulators
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (p_vld_reg) begin
            acc_re_reg <= sat_add64(acc_re_reg, 64'(pr_reg));
            acc_im_reg <= sat_add64(acc_im_reg, 64'(pi_reg));
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (cmd.finish) begin
            out_bra_reg <= bra_reg;
            out_ket_reg <= ket_reg;
            out_re_reg  <= sat32_64(acc_re_reg);
            out_im_reg  <= sat32_64(acc_im_reg);
        end
    end

    assign sts.pipe_busy = rd_vld_reg | m1_vld_reg | t_vld_reg | m2_vld_reg | p_vld_reg;
    assign sts.out_full  = out_vld_reg;
    assign m_tvalid    = out_vld_reg;
    assign bra_band    = out_bra_reg;
    assign ket_band    = out_ket_reg;
    assign result_real = out_re_reg;
    assign result_imag = out_im_reg;
endmodule

FILE: rtl/cbp_controller.sv
// request decoding, configuration registers and term sequencer
// depends on cbp_pkg and the assertion header
`include "complex_basis_projection_assert.svh"
module cbp_controller import cbp_pkg::*; #(
    parameter int MAX_ORBITALS = DEF_MAX_ORBITALS,
    parameter int MAX_BANDS    = DEF_MAX_BANDS,
    parameter int MAX_SPINORS  = DEF_MAX_SPINORS,
    localparam int ORB_W  = MAX_ORBITALS > 1 ? $clog2(MAX_ORBITALS) : 1,
    localparam int SP_W   = MAX_SPINORS > 1 ? $clog2(MAX_SPINORS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       req_type,
    input  logic [5:0]       first_index,
    input  logic [5:0]       second_index,
    output cbp_cmd_t         cmd,
    input  cbp_sts_t         sts,
    output logic [SP_W-1:0]  spin,
    output logic [ORB_W-1:0] row,
    output logic [ORB_W-1:0] col
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    state_t state_reg, state_next;
    logic [6:0] orb_cnt_reg, orb_cnt_next;
    logic [6:0] band_cnt_reg, band_cnt_next;
    logic [1:0] sp_cnt_reg, sp_cnt_next;
    logic [SP_W-1:0]  spin_reg, spin_next;
    logic [ORB_W-1:0] row_reg, row_next;
    logic [ORB_W-1:0] col_reg, col_next;
    logic accept, col_last, row_last, spin_last;

    // written value of zero becomes one, above the maximum becomes the maximum
    function automatic logic [6:0] clamp7(input logic [6:0] v, input int maxv);
        if (v == 7'd0) begin
            return 7'd1;
        end else if (32'(v) > maxv) begin
            return 7'(maxv);
        end
        return v;
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign col_last  = (32'(col_reg) + 32'd1) == 32'(orb_cnt_reg);
    assign row_last  = (32'(row_reg) + 32'd1) == 32'(orb_cnt_reg);
    assign spin_last = (32'(spin_reg) + 32'd1) == 32'(sp_cnt_reg);

    // next state, commands and counters
    always_comb begin
        state_next    = state_reg;
        orb_cnt_next  = orb_cnt_reg;
        band_cnt_next = band_cnt_reg;
        sp_cnt_next   = sp_cnt_reg;
        spin_next     = spin_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cmd           = '0;
        s_tready      = (state_reg == ST_IDLE);

        if (cfg_we) begin
            case (cfg_index)
                CFG_ORBITALS: orb_cnt_next  = clamp7(cfg_data, MAX_ORBITALS);
                CFG_BANDS:    band_cnt_next = clamp7(cfg_data, MAX_BANDS);
                CFG_SPINORS:  sp_cnt_next   = 2'(clamp7({5'd0, cfg_data[1:0]}, MAX_SPINORS));
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (req_type)
                        REQ_LOAD_POT: cmd.load_pot = 1'b1;
                        REQ_LOAD_WFC: cmd.load_wfc = 1'b1;
                        REQ_COMPUTE: begin
                            cmd.start = 1'b1;
                            spin_next = '0;
                            row_next  = '0;
                            col_next  = '0;
                            // bands at or beyond band_count give a zero result
                            if ((7'(first_index) < band_cnt_reg)
                                && (7'(second_index) < band_cnt_reg)) begin
                                state_next = ST_RUN;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (!col_last) begin
                    col_next = col_reg + 1'b1;
                end else begin
                    col_next = '0;
                    if (!row_last) begin
                        row_next = row_reg + 1'b1;
                    end else begin
                        row_next = '0;
                        if (!spin_last) begin
                            spin_next = spin_reg + 1'b1;
                        end else begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_full) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            orb_cnt_reg  <= ORBITALS_RESET;
            band_cnt_reg <= BANDS_RESET;
            sp_cnt_reg   <= SPINORS_RESET;
            spin_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            orb_cnt_reg  <= clamp7(orb_cnt_next, MAX_ORBITALS);
            band_cnt_reg <= clamp7(band_cnt_next, MAX_BANDS);
            sp_cnt_reg   <= 2'(clamp7({5'd0, sp_cnt_next}, MAX_SPINORS));
            spin_reg     <= spin_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    assign spin = spin_reg;
    assign row  = row_reg;
    assign col  = col_reg;

    // checks
    `CBP_ASSERT(a_finish_free, cmd.finish |-> !sts.out_full, "result register overwritten")
    `CBP_ASSERT_NEXT(a_finish_shows, cmd.finish, sts.out_full, "finished result not shown")
    `CBP_ASSERT(a_idle_drained, s_tready |-> !sts.pipe_busy, "item taken with terms in flight")
    `CBP_ASSERT(a_col_range, (state_reg == ST_RUN) |-> (32'(col_reg) < 32'(orb_cnt_reg)),
        "column counter beyond orbital count")
endmodule

FILE: test/testbench.sv
// self-checking testbench for complex_basis_projection: loads potential and
// wavefunction elements, requests projections and checks every result item
// depends on cbp_pkg and the complex_basis_projection rtl
module testbench;
    import cbp_pkg::*;

    localparam int ORB_MAX      = 64;
    localparam int BAND_MAX     = 64;
    localparam int SPIN_MAX     = 2;
    localparam int IDLE_LIMIT   = 60000;
    localparam int SETTLE_TICKS = 24;

    // request code that the block ignores
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [5:0]         bra;
        logic [5:0]         ket;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } projection_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    // local copy of the block's stores and registers
    logic signed [31:0] pot_re [ORB_MAX*ORB_MAX];
    logic signed [31:0] pot_im [ORB_MAX*ORB_MAX];
    logic signed [31:0] wfc_re [SPIN_MAX*BAND_MAX*ORB_MAX];
    logic signed [31:0] wfc_im [SPIN_MAX*BAND_MAX*ORB_MAX];
    int unsigned orbitals_in_use;
    int unsigned bands_in_use;
    int unsigned spinors_in_use;

    projection_t pending_projections[$];
    int          error_count;
    int          idle_ticks;
    int          ready_hold;
    bit          no_idle;

    complex_basis_projection u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------- fixed-point helpers ----------------
    function automatic longint q_mul(longint a, longint b);
        return (a * b + 64'sd8388608) >>> 24;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint acc_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0) return 64'sh7fffffffffffffff;
        if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
        return s;
    endfunction

    function automatic int unsigned clamp_count(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int wfc_slot(int s, int band, int orb);
        return (s * BAND_MAX + band) * ORB_MAX + orb;
    endfunction

    // sum of conj(W[bra,r]) V[r,c] W[ket,c] over spinors, rows, columns
    function automatic projection_t project_element(logic [5:0] bra, logic [5:0] ket);
        projection_t p;
        longint acc_re, acc_im, br, bi, vr, vi, kr, ki, tr, ti;
        int bw, kw;
        acc_re = 0;
        acc_im = 0;
        if (bra < bands_in_use && ket < bands_in_use) begin
            for (int s = 0; s < spinors_in_use; s++) begin
                for (int r = 0; r < orbitals_in_use; r++) begin
                    bw = wfc_slot(s, bra, r);
                    br = wfc_re[bw];
                    bi = wfc_im[bw];
                    for (int c = 0; c < orbitals_in_use; c++) begin
                        kw = wfc_slot(s, ket, c);
                        vr = pot_re[r*ORB_MAX + c];
                        vi = pot_im[r*ORB_MAX + c];
                        kr = wfc_re[kw];
                        ki = wfc_im[kw];
                        tr = clip32(q_mul(vr, kr) - q_mul(vi, ki));
                        ti = clip32(q_mul(vr, ki) + q_mul(vi, kr));
                        acc_re = acc_add(acc_re, q_mul(br, tr) + q_mul(bi, ti));
                        acc_im = acc_add(acc_im, q_mul(br, ti) - q_mul(bi, tr));
                    end
                end
            end
        end
        p.bra = bra;
        p.ket = ket;
        p.re  = 32'(clip32(acc_re));
        p.im  = 32'(clip32(acc_im));
        return p;
    endfunction

    // ---------------- random sources ----------------
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh01ffffff);
        endcase
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(logic [1:0] idx, logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ORBITALS: orbitals_in_use = clamp_count(value, ORB_MAX);
            CFG_BANDS:    bands_in_use    = clamp_count(value, BAND_MAX);
            CFG_SPINORS:  spinors_in_use  = clamp_count(value & 7'h3, SPIN_MAX);
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // sends one item; entered and left just after a falling edge
    task automatic send_item(logic [1:0] req, logic [5:0] i1, logic [5:0] i2,
                             logic sp, logic [31:0] re, logic [31:0] im);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, im, re, sp, i2, i1};
        do @(posedge aclk); while (!s_tready);
        // update local stores or queue the expected projection
        case (req)
            REQ_LOAD_POT: begin
                pot_re[i1*ORB_MAX + i2] = re;
                pot_im[i1*ORB_MAX + i2] = im;
            end
            REQ_LOAD_WFC: begin
                wfc_re[wfc_slot(sp, i1, i2)] = re;
                wfc_im[wfc_slot(sp, i1, i2)] = im;
            end
            REQ_COMPUTE: pending_projections.insert(pending_projections.size(),
                                                    project_element(i1, i2));
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_projections.size() == 0);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic set_sizes(logic [6:0] orb, logic [6:0] band, logic [6:0] spin);
        drain();
        write_reg(CFG_ORBITALS, orb);
        write_reg(CFG_BANDS, band);
        write_reg(CFG_SPINORS, spin);
    endtask

    // writes every element that a compute under the current sizes reads
    task automatic load_region();
        for (int r = 0; r < orbitals_in_use; r++)
            for (int c = 0; c < orbitals_in_use; c++)
                send_item(REQ_LOAD_POT, 6'(r), 6'(c), 1'($urandom), rand_q(), rand_q());
        for (int s = 0; s < spinors_in_use; s++)
            for (int b = 0; b < bands_in_use; b++)
                for (int o = 0; o < orbitals_in_use; o++)
                    send_item(REQ_LOAD_WFC, 6'(b), 6'(o), 1'(s), rand_q(), rand_q());
    endtask

    task automatic random_traffic(int n);
        int k;
        logic [5:0] bra, ket;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 70) begin
                bra = ($urandom_range(0, 9) == 0) ? 6'($urandom) :
                      6'($urandom_range(0, bands_in_use - 1));
                ket = ($urandom_range(0, 9) == 0) ? 6'($urandom) :
                      6'($urandom_range(0, bands_in_use - 1));
                send_item(REQ_COMPUTE, bra, ket, 1'($urandom), $urandom, $urandom);
            end else if (k < 80) begin
                send_item(REQ_LOAD_POT, 6'($urandom), 6'($urandom), 1'($urandom),
                          rand_q(), rand_q());
            end else if (k < 92) begin
                send_item(REQ_LOAD_WFC, 6'($urandom), 6'($urandom), 1'($urandom),
                          rand_q(), rand_q());
            end else begin
                send_item(REQ_RESERVED, 6'($urandom), 6'($urandom), 1'($urandom),
                          $urandom, $urandom);
            end
        end
    endtask

    // ---------------- tests ----------------
    // register limits, extreme values, corner indices, unused code, bad bands
    task automatic test_directed();
        set_sizes(7'd2, 7'd0, 7'd3);
        send_item(REQ_LOAD_POT, 6'd0, 6'd0, 1'b0, 32'h7fffffff, 32'h80000000);
        send_item(REQ_LOAD_POT, 6'd0, 6'd1, 1'b1, 32'h80000000, 32'h80000000);
        send_item(REQ_LOAD_POT, 6'd1, 6'd0, 1'b0, 32'h7fffffff, 32'h7fffffff);
        send_item(REQ_LOAD_POT, 6'd1, 6'd1, 1'b0, 32'h01000000, 32'h00000000);
        send_item(REQ_LOAD_POT, 6'd63, 6'd63, 1'b1, 32'hffffffff, 32'h00000001);
        send_item(REQ_LOAD_WFC, 6'd0, 6'd0, 1'b0, 32'h7fffffff, 32'h7fffffff);
        send_item(REQ_LOAD_WFC, 6'd0, 6'd1, 1'b0, 32'h80000000, 32'h7fffffff);
        send_item(REQ_LOAD_WFC, 6'd0, 6'd0, 1'b1, 32'h01000000, 32'hff000000);
        send_item(REQ_LOAD_WFC, 6'd0, 6'd1, 1'b1, 32'h00800000, 32'h00000000);
        send_item(REQ_LOAD_WFC, 6'd63, 6'd63, 1'b1, 32'h00000000, 32'hffffffff);
        send_item(REQ_RESERVED, 6'h3f, 6'h3f, 1'b1, 32'hffffffff, 32'hffffffff);
        send_item(REQ_COMPUTE, 6'd0, 6'd0, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd0, 6'd1, 1'b1, 32'hffffffff, 32'hffffffff);
        send_item(REQ_COMPUTE, 6'd63, 6'd0, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd63, 6'd63, 1'b0, 32'h0, 32'h0);
        // same data with one spinor, after the orbital register was set too high
        set_sizes(7'd127, 7'd1, 7'd0);
        write_reg(CFG_ORBITALS, 7'd2);
        send_item(REQ_COMPUTE, 6'd0, 6'd0, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd1, 6'd0, 1'b0, 32'h0, 32'h0);
    endtask

    // all 64 bands in use with a single orbital, outermost band computed
    task automatic test_band_limit();
        set_sizes(7'd1, 7'd127, 7'd1);
        send_item(REQ_LOAD_POT, 6'd0, 6'd0, 1'b0, rand_q(), rand_q());
        send_item(REQ_LOAD_WFC, 6'd0, 6'd0, 1'b0, rand_q(), rand_q());
        send_item(REQ_LOAD_WFC, 6'd63, 6'd0, 1'b0, rand_q(), rand_q());
        send_item(REQ_COMPUTE, 6'd63, 6'd63, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd0, 6'd63, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd63, 6'd0, 1'b0, 32'h0, 32'h0);
    endtask

    // mostly small sizes with random content and noise
    task automatic test_random_sizes();
        for (int ph = 0; ph < 3; ph++) begin
            no_idle = (ph == 1);
            set_sizes(7'($urandom_range(1, 3)), 7'($urandom_range(1, 3)),
                      7'($urandom_range(1, 2)));
            load_region();
            random_traffic(10);
        end
        no_idle = 0;
    endtask

    // receiver holds off while computes keep arriving
    task automatic test_backpressure();
        set_sizes(7'd2, 7'd2, 7'd1);
        load_region();
        ready_hold = 1500;
        for (int i = 0; i < 8; i++)
            send_item(REQ_COMPUTE, 6'($urandom_range(0, 2)), 6'($urandom_range(0, 2)),
                      1'b0, 32'h0, 32'h0);
    endtask

    // wider orbital count with both spinors, a single band pair
    task automatic test_max_orbitals();
        set_sizes(7'd5, 7'd1, 7'd2);
        no_idle = 1;
        load_region();
        no_idle = 0;
        send_item(REQ_COMPUTE, 6'd0, 6'd0, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd0, 6'd1, 1'b0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 6'd0, 6'd0, 1'b1, 32'h0, 32'h0);
    endtask

    // ---------------- result side ----------------
    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // receiver readiness, with random stalls and a commanded hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 199) == 0) begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(15, 60);
            end else begin
                m_tready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // compare each result item with the oldest expected projection
    always @(posedge aclk) begin
        projection_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[5:0], m_tdata[11:6], m_tdata[43:12], m_tdata[75:44]};
            if (pending_projections.size() == 0) begin
                $display("unexpected result item at %0t", $realtime);
                error_count++;
            end else begin
                want = pending_projections.pop_front();
                if (got.bra != want.bra) report_mismatch("bra_band", got.bra, want.bra);
                if (got.ket != want.ket) report_mismatch("ket_band", got.ket, want.ket);
                if (got.re != want.re)   report_mismatch("result_real", got.re, want.re);
                if (got.im != want.im)   report_mismatch("result_imag", got.im, want.im);
            end
        end
    end

    // watchdog on cycles without any accepted item or register write
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_ticks <= 0;
        end else begin
            idle_ticks <= idle_ticks + 1;
            if (idle_ticks >= IDLE_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        error_count     = 0;
        idle_ticks      = 0;
        ready_hold      = 0;
        no_idle         = 0;
        orbitals_in_use = ORB_MAX;
        bands_in_use    = BAND_MAX;
        spinors_in_use  = 1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_band_limit();
        test_random_sizes();
        test_backpressure();
        test_max_orbitals();
        drain();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cbp_pkg.sv
rtl/cbp_ram.sv
rtl/cbp_datapath.sv
rtl/cbp_controller.sv
rtl/complex_basis_projection.sv
test/testbench.sv
